FILE: sv/tdpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpb_pkg
// Shared types and constants of the timed delay and period batcher.
// ----------------------------------------------------------------------------
package tdpb_pkg;

    localparam int DELAY_DEPTH_DEF = 32;
    localparam int BATCH_DEPTH_DEF = 32;

    localparam int CFG_W  = 31;
    localparam int TIME_W = 32;
    localparam int TAG_W  = 32;

    localparam logic CFG_DELAY  = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] record_time;
        logic [TAG_W-1:0]  record_tag;
    } t_in;

    typedef struct packed {
        logic [TIME_W-1:0] out_time;
        logic [TAG_W-1:0]  out_tag;
        logic              last_of_run;
    } t_out;

    typedef struct packed {
        logic accept;
        logic fifo_rd;
        logic fifo_pop;
        logic fifo_push;
        logic div_start;
        logic set_period;
        logic bat_clr_idx;
        logic bat_rd;
        logic bat_clear;
        logic bat_push;
        logic emit_s2;
        logic emit_bat;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic delay_zero;
        logic period_zero;
        logic fifo_full;
        logic fifo_empty;
        logic due;
        logic div_busy;
        logic pnum_eq;
        logic bat_full;
        logic bat_idx_end;
        logic can_emit;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/tdpb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdpb_ram #(
    parameter int W = 64,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/tdpb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpb_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tdpb_pkg::TIME_W-1:0]   i_dividend,
    input  logic [tdpb_pkg::CFG_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic [tdpb_pkg::TIME_W-1:0]   o_quotient
);
    import tdpb_pkg::*;
    localparam int NW = $clog2(TIME_W + 1);

    logic [TIME_W-1:0] r_rem, r_quo, n_rem, n_quo;
    logic [NW-1:0]     r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic [TIME_W-1:0] trial, dvs;
    logic              qbit;

    always_comb begin
        dvs   = {{(TIME_W - CFG_W){1'b0}}, i_divisor};
        trial = {r_rem[TIME_W-2:0], r_quo[TIME_W-1]};
        qbit  = (trial >= dvs);
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = NW'(TIME_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = qbit ? (trial - dvs) : trial;
            n_quo  = {r_quo[TIME_W-2:0], qbit};
            n_cnt  = r_cnt - NW'(1);
            n_busy = (r_cnt != NW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

FILE: sv/tdpb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpb_ctrl
// Sequencer: delay FIFO release loop, batching and result hand-off.
// ----------------------------------------------------------------------------
module tdpb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tdpb_pkg::t_sts i_sts,
    output tdpb_pkg::t_cmd o_cmd
);
    import tdpb_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FRD   = 4'd1;
    localparam logic [3:0] S_FPOP  = 4'd2;
    localparam logic [3:0] S_PUSH  = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_S2    = 4'd6;
    localparam logic [3:0] S_S2E   = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_FLCHK = 4'd9;
    localparam logic [3:0] S_FLEM  = 4'd10;
    localparam logic [3:0] S_BPUSH = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] r_state, n_state, r_ret, n_ret;
    t_cmd       cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_sts.delay_zero) begin
                        n_ret   = S_DONE;
                        n_state = S_S2;
                    end else if (i_sts.fifo_full) begin
                        n_state = S_FRD;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_FRD: begin
                cmd.fifo_rd = 1'b1;
                n_state     = S_FPOP;
            end
            S_FPOP: begin
                cmd.fifo_pop = 1'b1;
                n_ret        = S_PUSH;
                n_state      = S_S2;
            end
            S_PUSH: begin
                cmd.fifo_push = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (i_sts.fifo_empty) begin
                    n_state = S_DONE;
                end else begin
                    cmd.fifo_rd = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.due) begin
                    cmd.fifo_pop = 1'b1;
                    n_ret        = S_CHK;
                    n_state      = S_S2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_S2: begin
                if (i_sts.period_zero) begin
                    n_state = S_S2E;
                end else begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIVW;
                end
            end
            S_S2E: begin
                if (i_sts.can_emit) begin
                    cmd.emit_s2 = 1'b1;
                    n_state     = r_ret;
                end
            end
            S_DIVW: begin
                if (!i_sts.div_busy) begin
                    if (i_sts.pnum_eq && !i_sts.bat_full) begin
                        n_state = S_BPUSH;
                    end else begin
                        cmd.set_period  = !i_sts.pnum_eq;
                        cmd.bat_clr_idx = 1'b1;
                        n_state         = S_FLCHK;
                    end
                end
            end
            S_FLCHK: begin
                if (i_sts.bat_idx_end) begin
                    cmd.bat_clear = 1'b1;
                    n_state       = S_BPUSH;
                end else begin
                    cmd.bat_rd = 1'b1;
                    n_state    = S_FLEM;
                end
            end
            S_FLEM: begin
                if (i_sts.can_emit) begin
                    cmd.emit_bat = 1'b1;
                    n_state      = S_FLCHK;
                end
            end
            S_BPUSH: begin
                cmd.bat_push = 1'b1;
                n_state      = r_ret;
            end
            S_DONE: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_DONE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;
endmodule

FILE: sv/tdpb_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpb_dpath
// Datapath: config, start stamp, delay FIFO, batch store, divider, output.
// ----------------------------------------------------------------------------
module tdpb_dpath #(
    parameter int DELAY_DEPTH = tdpb_pkg::DELAY_DEPTH_DEF,
    parameter int BATCH_DEPTH = tdpb_pkg::BATCH_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [tdpb_pkg::CFG_W-1:0] i_cfg_data,
    input  tdpb_pkg::t_in              i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tdpb_pkg::t_out             o_out,
    input  tdpb_pkg::t_cmd             i_cmd,
    output tdpb_pkg::t_sts             o_sts
);
    import tdpb_pkg::*;

    localparam int FPW = $clog2(DELAY_DEPTH);
    localparam int FCW = $clog2(DELAY_DEPTH + 1);
    localparam int BPW = $clog2(BATCH_DEPTH);
    localparam int BCW = $clog2(BATCH_DEPTH + 1);

    logic [CFG_W-1:0]  r_delay, r_period;
    logic [TIME_W-1:0] r_start, r_cur_period, r_now;
    logic              r_start_seen;
    t_in               r_in, r_s2;
    logic [FPW-1:0]    r_head, r_tail;
    logic [FCW-1:0]    r_fcnt;
    logic [BCW-1:0]    r_bcnt, r_bidx;
    logic              r_pend_valid, r_out_valid;
    t_in               r_pend;
    t_out              r_out;

    t_in               fifo_rdata, bat_rdata, emit_rec;
    logic              div_busy, out_free, emit;
    logic [TIME_W-1:0] quotient;
    logic [TIME_W:0]   due_sum;

    tdpb_ram #(.W($bits(t_in)), .D(DELAY_DEPTH)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fifo_push),
        .i_waddr (r_tail),
        .i_wdata (r_in),
        .i_re    (i_cmd.fifo_rd),
        .i_raddr (r_head),
        .o_rdata (fifo_rdata)
    );

    tdpb_ram #(.W($bits(t_in)), .D(BATCH_DEPTH)) u_bat_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.bat_push),
        .i_waddr (r_bcnt[BPW-1:0]),
        .i_wdata (r_s2),
        .i_re    (i_cmd.bat_rd),
        .i_raddr (r_bidx[BPW-1:0]),
        .o_rdata (bat_rdata)
    );

    tdpb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_s2.record_time - r_start),
        .i_divisor  (r_period),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = i_cmd.emit_s2 || i_cmd.emit_bat;
    assign emit_rec = i_cmd.emit_bat ? bat_rdata : r_s2;
    assign due_sum  = {1'b0, fifo_rdata.record_time} + {{(TIME_W + 1 - CFG_W){1'b0}}, r_delay};

    always_comb begin
        o_sts             = '0;
        o_sts.delay_zero  = (r_delay == '0);
        o_sts.period_zero = (r_period == '0);
        o_sts.fifo_full   = (r_fcnt == FCW'(DELAY_DEPTH));
        o_sts.fifo_empty  = (r_fcnt == '0);
        o_sts.due         = (due_sum <= {1'b0, r_now});
        o_sts.div_busy    = div_busy;
        o_sts.pnum_eq     = (quotient == r_cur_period);
        o_sts.bat_full    = (r_bcnt == BCW'(BATCH_DEPTH));
        o_sts.bat_idx_end = (r_bidx == r_bcnt);
        o_sts.can_emit    = !r_pend_valid || out_free;
        o_sts.pend_valid  = r_pend_valid;
        o_sts.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay      <= '0;
            r_period     <= '0;
            r_start_seen <= 1'b0;
            r_cur_period <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_fcnt       <= '0;
            r_bcnt       <= '0;
            r_bidx       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_DELAY) begin
                    r_delay <= i_cfg_data;
                end
                if (i_cfg_addr == CFG_PERIOD) begin
                    r_period <= i_cfg_data;
                end
            end
            if (i_cmd.accept) begin
                r_start_seen <= 1'b1;
                if (!r_start_seen) begin
                    r_start <= i_in.record_time;
                end
            end
            if (i_cmd.fifo_pop) begin
                r_head <= (r_head == FPW'(DELAY_DEPTH - 1)) ? '0 : r_head + FPW'(1);
            end
            if (i_cmd.fifo_push) begin
                r_tail <= (r_tail == FPW'(DELAY_DEPTH - 1)) ? '0 : r_tail + FPW'(1);
            end
            if (i_cmd.fifo_push && !i_cmd.fifo_pop) begin
                r_fcnt <= r_fcnt + FCW'(1);
            end else if (i_cmd.fifo_pop && !i_cmd.fifo_push) begin
                r_fcnt <= r_fcnt - FCW'(1);
            end
            if (i_cmd.set_period) begin
                r_cur_period <= quotient;
            end
            if (i_cmd.bat_clr_idx) begin
                r_bidx <= '0;
            end else if (i_cmd.bat_rd) begin
                r_bidx <= r_bidx + BCW'(1);
            end
            if (i_cmd.bat_clear) begin
                r_bcnt <= '0;
            end else if (i_cmd.bat_push) begin
                r_bcnt <= r_bcnt + BCW'(1);
            end
            if (i_cmd.finish || (emit && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end else if (emit) begin
                r_pend_valid <= 1'b1;
            end
        end
        if (i_cmd.accept) begin
            r_in  <= i_in;
            r_s2  <= i_in;
            r_now <= i_in.record_time;
        end
        if (i_cmd.fifo_pop) begin
            r_s2 <= fifo_rdata;
        end
        if (emit) begin
            r_pend <= emit_rec;
            if (r_pend_valid) begin
                r_out <= '{r_pend.record_time, r_pend.record_tag, 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_out <= '{r_pend.record_time, r_pend.record_tag, 1'b1};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FCW'(DELAY_DEPTH))
        else $error("delay FIFO count beyond depth");
    a_bat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= BCW'(BATCH_DEPTH))
        else $error("batch count beyond depth");
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_pend_valid || out_free))
        else $error("item emitted with no room");
    a_finish_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_out_valid && r_out.last_of_run && !r_pend_valid))
        else $error("final item not marked");
`endif
endmodule

FILE: sv/timed_delay_and_period_batcher.sv
`timescale 1ns / 1ps
// Flow: one item at a time (o_in_ready is high only in the idle state); with
//   batching on, an item may release FIFO records, each passing through the
//   radix-2 divider, and may flush the batched records; output stalls hold
//   the sequencer.
// Reset: synchronous active low; clears config, counts, the start-seen flag and output valid.
// ----------------------------------------------------------------------------
// timed_delay_and_period_batcher
// Delays timestamped items in a FIFO and groups released items by period.
// ----------------------------------------------------------------------------
module timed_delay_and_period_batcher #(
    parameter int DELAY_DEPTH = tdpb_pkg::DELAY_DEPTH_DEF,
    parameter int BATCH_DEPTH = tdpb_pkg::BATCH_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [tdpb_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tdpb_pkg::t_in              i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tdpb_pkg::t_out             o_out
);
    import tdpb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tdpb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tdpb_dpath #(.DELAY_DEPTH(DELAY_DEPTH), .BATCH_DEPTH(BATCH_DEPTH)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );
endmodule
